>>> hw/rtl/srfd_pkg.sv
// ----------------------------------------------------------------------------
// srfd_pkg: shared types and constants of the sprite RLE frame decoder
// Field widths, register map, reset values and the result record.
// ----------------------------------------------------------------------------
package srfd_pkg;

   localparam int unsigned MAX_DIM_DEFAULT = 1024;

   localparam int unsigned CFG_W   = 11;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LIT_W   = 7;
   localparam int unsigned X_W     = 10;
   localparam int unsigned Y_W     = 10;
   localparam int unsigned ADDR_W  = 20;
   localparam int unsigned COLOR_W = 8;
   localparam int unsigned PADDR_W = 3;
   localparam int unsigned PDATA_W = 32;

   // control byte that closes a line; below opens a literal run, above skips
   localparam logic [BYTE_W-1:0] LINE_END = 8'h80;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd256;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd256;

   // register index, taken from paddr[2]
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [X_W-1:0]     pixel_x;
      logic [Y_W-1:0]     pixel_y;
      logic [ADDR_W-1:0]  pixel_address;
      logic [COLOR_W-1:0] color_index;
      logic               frame_done;
   } rsp_type;

   typedef struct packed {
      logic    push;
      rsp_type data;
   } push_type;

endpackage

>>> hw/rtl/srfd_csr.sv
// ----------------------------------------------------------------------------
// srfd_csr: frame size registers
// APB-style register file holding frame width and height, plus clamped copies.
// ----------------------------------------------------------------------------
module srfd_csr #(
   parameter int unsigned MAX_DIM = srfd_pkg::MAX_DIM_DEFAULT,
   localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [srfd_pkg::PADDR_W-1:0]  paddr,
   input  logic [srfd_pkg::PDATA_W-1:0]  pwdata,
   output logic [srfd_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output logic [DIM_W-1:0]              width_dim,
   output logic [DIM_W-1:0]              height_dim
);

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [srfd_pkg::CFG_W-1:0] v);
      logic [31:0] wide;
      begin
         wide = 32'(v);
         if (wide == 32'd0) begin
            return DIM_W'(1);
         end
         if (wide > 32'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
         end
         return DIM_W'(wide);
      end
   endfunction

   logic [srfd_pkg::CFG_W-1:0] width_raw_ff, width_raw_in;
   logic [srfd_pkg::CFG_W-1:0] height_raw_ff, height_raw_in;
   logic [DIM_W-1:0]           width_dim_ff, width_dim_in;
   logic [DIM_W-1:0]           height_dim_ff, height_dim_in;
   logic                       wr_en;
   logic                       reg_sel;
   logic [srfd_pkg::CFG_W-1:0] wdata;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];
   assign wdata   = pwdata[srfd_pkg::CFG_W-1:0];

   always_comb begin
      width_raw_in  = width_raw_ff;
      height_raw_in = height_raw_ff;
      width_dim_in  = width_dim_ff;
      height_dim_in = height_dim_ff;
      if (wr_en) begin
         case (reg_sel)
            srfd_pkg::REG_FRAME_WIDTH: begin
               width_raw_in = wdata;
               width_dim_in = clamp_dim(wdata);
            end
            srfd_pkg::REG_FRAME_HEIGHT: begin
               height_raw_in = wdata;
               height_dim_in = clamp_dim(wdata);
            end
            default: begin
               width_raw_in = width_raw_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         srfd_pkg::REG_FRAME_WIDTH:  prdata = srfd_pkg::PDATA_W'(width_raw_ff);
         srfd_pkg::REG_FRAME_HEIGHT: prdata = srfd_pkg::PDATA_W'(height_raw_ff);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff  <= srfd_pkg::WIDTH_RESET;
         height_raw_ff <= srfd_pkg::HEIGHT_RESET;
         width_dim_ff  <= clamp_dim(srfd_pkg::WIDTH_RESET);
         height_dim_ff <= clamp_dim(srfd_pkg::HEIGHT_RESET);
      end else begin
         width_raw_ff  <= width_raw_in;
         height_raw_ff <= height_raw_in;
         width_dim_ff  <= width_dim_in;
         height_dim_ff <= height_dim_in;
      end
   end

   assign width_dim  = width_dim_ff;
   assign height_dim = height_dim_ff;

endmodule

>>> hw/rtl/srfd_decode.sv
// ----------------------------------------------------------------------------
// srfd_decode: byte register and run-length decode step
// Holds the incoming byte, updates run, column and row state, forms results.
// ----------------------------------------------------------------------------
module srfd_decode #(
   parameter int unsigned MAX_DIM = srfd_pkg::MAX_DIM_DEFAULT,
   localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [srfd_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic [DIM_W-1:0]             width_dim,
   input  logic [DIM_W-1:0]             height_dim,
   input  logic                         out_space,
   output srfd_pkg::push_type           out_push
);

   localparam int unsigned SKIP_W = ((DIM_W > srfd_pkg::LIT_W) ? DIM_W : srfd_pkg::LIT_W) + 1;
   localparam int unsigned PROD_W = (2 * DIM_W > srfd_pkg::ADDR_W) ? 2 * DIM_W
                                                                  : srfd_pkg::ADDR_W;

   logic                          in_valid_ff, in_valid_in;
   logic [srfd_pkg::BYTE_W-1:0]   byte_ff, byte_in;
   logic [srfd_pkg::LIT_W-1:0]    lit_ff, lit_in;
   logic [DIM_W-1:0]              col_ff, col_in;
   logic [DIM_W-1:0]              rows_ff, rows_in;

   logic                          accept;
   logic                          fire;
   logic [DIM_W-1:0]              col_step;
   logic [SKIP_W-1:0]             skip_sum;
   logic [DIM_W-1:0]              col_skip;
   logic [DIM_W:0]                rows_next;
   logic [DIM_W-1:0]              row_y;
   logic [PROD_W-1:0]             addr_full;
   logic                          in_frame;

   assign fire      = in_valid_ff && out_space;
   assign req_ready = !in_valid_ff || out_space;
   assign accept    = req_valid && req_ready;

   // hold the byte until the decode step takes it
   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         byte_in     = req_data_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // column moves saturate at the frame width
   assign col_step  = (col_ff < width_dim) ? col_ff + DIM_W'(1) : width_dim;
   assign skip_sum  = SKIP_W'(col_ff) + SKIP_W'(byte_ff[srfd_pkg::LIT_W-1:0]);
   assign col_skip  = (skip_sum > SKIP_W'(width_dim)) ? width_dim : DIM_W'(skip_sum);
   assign rows_next = {1'b0, rows_ff} + (DIM_W+1)'(1);

   // rows fill bottom up: the first line is the last row
   assign row_y     = height_dim - DIM_W'(1) - rows_ff;
   assign addr_full = PROD_W'(row_y) * PROD_W'(width_dim) + PROD_W'(col_ff);
   assign in_frame  = (col_ff < width_dim) && (rows_ff < height_dim);

   always_comb begin
      lit_in   = lit_ff;
      col_in   = col_ff;
      rows_in  = rows_ff;
      out_push = '0;
      if (fire) begin
         if (lit_ff != '0) begin
            lit_in = lit_ff - srfd_pkg::LIT_W'(1);
            col_in = col_step;
            if (in_frame) begin
               out_push.push               = 1'b1;
               out_push.data.pixel_x       = srfd_pkg::X_W'(col_ff);
               out_push.data.pixel_y       = srfd_pkg::Y_W'(row_y);
               out_push.data.pixel_address = addr_full[srfd_pkg::ADDR_W-1:0];
               out_push.data.color_index   = byte_ff;
            end
         end else if (byte_ff < srfd_pkg::LINE_END) begin
            lit_in = byte_ff[srfd_pkg::LIT_W-1:0];
         end else if (byte_ff > srfd_pkg::LINE_END) begin
            col_in = col_skip;
         end else begin
            // line end: back to column zero, next row up or frame done
            col_in = '0;
            if (rows_next >= {1'b0, height_dim}) begin
               rows_in                  = '0;
               lit_in                   = '0;
               out_push.push            = 1'b1;
               out_push.data.frame_done = 1'b1;
            end else begin
               rows_in = rows_next[DIM_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         lit_ff      <= '0;
         col_ff      <= '0;
         rows_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         lit_ff      <= lit_in;
         col_ff      <= col_in;
         rows_ff     <= rows_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

>>> hw/rtl/srfd_rsp_fifo.sv
// ----------------------------------------------------------------------------
// srfd_rsp_fifo: two-entry result buffer
// Output register plus skid entry so decode runs while a result is held.
// ----------------------------------------------------------------------------
module srfd_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  srfd_pkg::push_type  in_push,
   output logic                in_space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output srfd_pkg::rsp_type   rsp_data
);

   srfd_pkg::rsp_type mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign in_space  = (count_ff != 2'd2) || rsp_ready;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = in_push.push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      case ({in_push.push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_push.push) begin
         mem_ff[wr_ptr_ff] <= in_push.data;
      end
   end

endmodule

>>> hw/rtl/sprite_rle_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// sprite_rle_frame_decoder_unit: run-length coded sprite frame decoder
// Path: an accepted byte is held in the input byte register, and the decode step
// writes its result into the result buffer, which stalls the step while full.
// Throughput: one byte per cycle while the result buffer has space; the decode step is a single registered pass.
// Each byte gives at most one result: a pixel write or the frame-done marker.
// Reset (synchronous, active high) clears run, column and row state, empties
// the result buffer and loads width and height with 256.
// ----------------------------------------------------------------------------
//
// Structure:
//   srfd_csr      - frame width/height registers on the APB-style port; a
//                   clamped copy (0 -> 1, above MAX_DIM -> MAX_DIM) feeds the
//                   decoder so no clamp logic sits in the byte path.
//   srfd_decode   - input byte register and the decode step. Control bytes
//                   below 0x80 open a literal run, above 0x80 skip columns,
//                   0x80 closes the line. Literal bytes become pixels at
//                   (column, height-1-rows_done) with address y*width+x.
//   srfd_rsp_fifo - output register plus skid entry, so a byte transfer is
//                   taken while an earlier result still waits on rsp_ready.
//
module sprite_rle_frame_decoder_unit #(
   parameter int unsigned MAX_DIM = srfd_pkg::MAX_DIM_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   // byte input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [srfd_pkg::BYTE_W-1:0]   req_data_byte,

   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [srfd_pkg::X_W-1:0]      rsp_pixel_x,
   output logic [srfd_pkg::Y_W-1:0]      rsp_pixel_y,
   output logic [srfd_pkg::ADDR_W-1:0]   rsp_pixel_address,
   output logic [srfd_pkg::COLOR_W-1:0]  rsp_color_index,
   output logic                          rsp_frame_done,

   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [srfd_pkg::PADDR_W-1:0]  paddr,
   input  logic [srfd_pkg::PDATA_W-1:0]  pwdata,
   output logic [srfd_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);

   localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

   logic [DIM_W-1:0]   width_dim;
   logic [DIM_W-1:0]   height_dim;
   logic               out_space;
   srfd_pkg::push_type out_push;
   srfd_pkg::rsp_type  rsp_data;

   srfd_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .width_dim  (width_dim),
      .height_dim (height_dim)
   );

   // advance the held byte only when the result buffer can take its result
   srfd_decode #(
      .MAX_DIM (MAX_DIM)
   ) u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .width_dim     (width_dim),
      .height_dim    (height_dim),
      .out_space     (out_space),
      .out_push      (out_push)
   );

   srfd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_push   (out_push),
      .in_space  (out_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // unpack the held result onto the channel fields
   assign rsp_pixel_x       = rsp_data.pixel_x;
   assign rsp_pixel_y       = rsp_data.pixel_y;
   assign rsp_pixel_address = rsp_data.pixel_address;
   assign rsp_color_index   = rsp_data.color_index;
   assign rsp_frame_done    = rsp_data.frame_done;

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sprite RLE frame decoder
// Streams coded frame bytes through the byte channel, decodes each accepted
// transfer in a local model of the decoder and checks every result transfer,
// field by field and in order, under random stalls on both channels and
// across several frame width/height settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT  = 250000;
   localparam int SETTLE_TICKS = 6;     // byte register and result buffer plus margin
   localparam int REPORT_MAX   = 10;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [srfd_pkg::BYTE_W-1:0]   req_data_byte = '0;

   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [srfd_pkg::X_W-1:0]      rsp_pixel_x;
   logic [srfd_pkg::Y_W-1:0]      rsp_pixel_y;
   logic [srfd_pkg::ADDR_W-1:0]   rsp_pixel_address;
   logic [srfd_pkg::COLOR_W-1:0]  rsp_color_index;
   logic                          rsp_frame_done;

   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [srfd_pkg::PADDR_W-1:0]  paddr = '0;
   logic [srfd_pkg::PDATA_W-1:0]  pwdata = '0;
   logic [srfd_pkg::PDATA_W-1:0]  prdata;
   logic                          pready;

   sprite_rle_frame_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_color_index   (rsp_color_index),
      .rsp_frame_done    (rsp_frame_done),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Local decoder model: register copies and frame walk state
   // --------------------------------------------------------------------------
   logic [srfd_pkg::CFG_W-1:0] cfg_width  = srfd_pkg::WIDTH_RESET;
   logic [srfd_pkg::CFG_W-1:0] cfg_height = srfd_pkg::HEIGHT_RESET;
   int               run_left    = 0;   // literal bytes still owed by the run
   int               cursor_x    = 0;
   int               rows_filled = 0;   // rows closed so far, bottom first

   srfd_pkg::rsp_type           expected_writes[$];
   logic [srfd_pkg::BYTE_W-1:0] coded_bytes[$];
   int               bytes_queued   = 0;
   int               bytes_accepted = 0;
   int               mismatches     = 0;
   int               cycle_count    = 0;
   bit               no_idle        = 1'b0;

   // Walk one accepted byte through the frame state; queue the pixel write or
   // frame-done marker it produces, if any.
   function automatic void decode_byte(input logic [srfd_pkg::BYTE_W-1:0] b);
      int                w;
      int                h;
      int                y;
      int                cap;
      srfd_pkg::rsp_type r;
      // out-of-range sizes: zero acts as one, above the cap acts as the cap
      cap = int'(srfd_pkg::MAX_DIM_DEFAULT);
      w = (cfg_width == '0) ? 1 : (int'(cfg_width) > cap) ? cap : int'(cfg_width);
      h = (cfg_height == '0) ? 1 : (int'(cfg_height) > cap) ? cap : int'(cfg_height);
      r = '0;
      if (run_left > 0) begin
         run_left--;
         // drop pixels past the row end or above a lowered frame top
         if (cursor_x < w && rows_filled < h) begin
            y               = h - 1 - rows_filled;
            r.pixel_x       = srfd_pkg::X_W'(cursor_x);
            r.pixel_y       = srfd_pkg::Y_W'(y);
            r.pixel_address = srfd_pkg::ADDR_W'(y * w + cursor_x);
            r.color_index   = b;
            expected_writes.push_back(r);
         end
         cursor_x = (cursor_x + 1 > w) ? w : cursor_x + 1;
      end else if (b < srfd_pkg::LINE_END) begin
         run_left = int'(b);                  // zero opens an empty run
      end else if (b > srfd_pkg::LINE_END) begin
         cursor_x = cursor_x + int'(b) - int'(srfd_pkg::LINE_END);
         if (cursor_x > w) cursor_x = w;      // skips saturate at the width
      end else begin
         cursor_x = 0;
         rows_filled++;
         if (rows_filled >= h) begin
            // top row closed: rearm for the next frame
            run_left     = 0;
            rows_filled  = 0;
            r.frame_done = 1'b1;
            expected_writes.push_back(r);
         end
      end
   endfunction

   // --------------------------------------------------------------------------
   // Byte driver: present the next queued byte, hold it until its transfer
   // --------------------------------------------------------------------------
   bit req_taken = 1'b0;
   int req_gap   = 0;
   int rsp_stall = 0;

   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (no_idle || r < 55) return 0;
      if (r < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (coded_bytes.size() != 0) begin
            req_valid     <= 1'b1;
            req_data_byte <= coded_bytes.pop_front();
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result-side backpressure: mostly short stalls, a few long ones.
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (!reset && !no_idle && $urandom_range(0, 99) < 20) begin
         rsp_stall = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: decode byte transfers, check result transfers in order
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      srfd_pkg::rsp_type got;
      srfd_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            bytes_accepted++;
            decode_byte(req_data_byte);
         end
         if (rsp_valid && rsp_ready) begin
            got.pixel_x       = rsp_pixel_x;
            got.pixel_y       = rsp_pixel_y;
            got.pixel_address = rsp_pixel_address;
            got.color_index   = rsp_color_index;
            got.frame_done    = rsp_frame_done;
            if (expected_writes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected result: x=%0d y=%0d addr=%0d color=%0d done=%0d",
                           got.pixel_x, got.pixel_y, got.pixel_address,
                           got.color_index, got.frame_done);
            end else begin
               want = expected_writes.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("mismatch: expected x=%0d y=%0d addr=%0d color=%0d done=%0d",
                              want.pixel_x, want.pixel_y, want.pixel_address,
                              want.color_index, want.frame_done);
                     $display("          got      x=%0d y=%0d addr=%0d color=%0d done=%0d",
                              got.pixel_x, got.pixel_y, got.pixel_address,
                              got.color_index, got.frame_done);
                  end
               end
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   task automatic queue_byte(input logic [srfd_pkg::BYTE_W-1:0] b);
      coded_bytes.push_back(b);
      bytes_queued++;
   endtask

   // Wait until every byte is taken and every result has come back, then let
   // bytes without results drain out of the pipeline.
   task automatic wait_idle();
      while (bytes_accepted != bytes_queued || expected_writes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   // Setup cycle, then access cycle; the register loads at the edge where the
   // access phase meets pready.
   task automatic write_reg(input logic idx, input int value);
      logic [srfd_pkg::PDATA_W-1:0] wd;
      wd        = $urandom;                  // upper bits are don't-care
      wd[srfd_pkg::CFG_W-1:0] = value[srfd_pkg::CFG_W-1:0];
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= wd;
      @(negedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == srfd_pkg::REG_FRAME_WIDTH) cfg_width = wd[srfd_pkg::CFG_W-1:0];
      else cfg_height = wd[srfd_pkg::CFG_W-1:0];
   endtask

   task automatic set_frame(input int w, input int h);
      write_reg(srfd_pkg::REG_FRAME_WIDTH, w);
      write_reg(srfd_pkg::REG_FRAME_HEIGHT, h);
   endtask

   // One coded frame of gen_h lines: literal runs, skips and a little noise;
   // now and then the frame is cut short.
   task automatic queue_random_frame(input int gen_w, input int gen_h);
      int row;
      int seg;
      int segs;
      int n;
      int k;
      int pick;
      for (row = 0; row < gen_h; row++) begin
         if ($urandom_range(0, 99) < 4) return;
         segs = int'($urandom_range(0, 3));
         for (seg = 0; seg < segs; seg++) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 50) begin
               if ($urandom_range(0, 19) == 0) n = int'($urandom_range(0, 127));
               else n = int'($urandom_range(0, (gen_w > 6) ? 6 : gen_w + 1));
               queue_byte(srfd_pkg::BYTE_W'(n));
               for (k = 0; k < n; k++)
                  queue_byte(srfd_pkg::BYTE_W'($urandom_range(0, 255)));
            end else if (pick < 85) begin
               if ($urandom_range(0, 9) == 0) n = int'($urandom_range(1, 127));
               else n = int'($urandom_range(1, 4));
               queue_byte(srfd_pkg::BYTE_W'(int'(srfd_pkg::LINE_END) + n));
            end else begin
               queue_byte(srfd_pkg::BYTE_W'($urandom_range(0, 255)));
            end
         end
         queue_byte(srfd_pkg::LINE_END);
      end
   endtask

   task automatic run_random(input int gen_w, input int gen_h, input int count,
                             input bit calm);
      int start;
      no_idle = calm;
      @(posedge clock);
      start = bytes_queued;
      while (bytes_queued - start < count) queue_random_frame(gen_w, gen_h);
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset sizes: empty run, literal extremes, skips saturating the
      // column at the width, pixels dropped past the row, line end
      @(posedge clock);
      queue_byte(8'h00);
      queue_byte(8'h02); queue_byte(8'h00); queue_byte(8'hFF);
      queue_byte(8'h81);
      queue_byte(8'hFF); queue_byte(8'hFF); queue_byte(8'h83);
      queue_byte(8'h01); queue_byte(8'h12);
      queue_byte(srfd_pkg::LINE_END);
      wait_idle();

      // zero sizes act as one: the open row count already reaches the new
      // height, so the first line end gives frame done; then a single pixel,
      // one dropped, frame done
      set_frame(0, 0);
      @(posedge clock);
      queue_byte(srfd_pkg::LINE_END);
      queue_byte(8'h02); queue_byte(8'h11); queue_byte(8'h22);
      queue_byte(srfd_pkg::LINE_END);
      wait_idle();

      // oversize registers clamp to the cap: top-row addresses
      set_frame(2047, 2047);
      @(posedge clock);
      queue_byte(8'h01); queue_byte(8'hA5);
      queue_byte(8'hFF);
      queue_byte(8'h01); queue_byte(8'h3C);
      wait_idle();

      // close two rows, then lower the height under them: literals drop and
      // the next line end gives frame done
      set_frame(8, 1024);
      @(posedge clock);
      queue_byte(srfd_pkg::LINE_END); queue_byte(srfd_pkg::LINE_END);
      wait_idle();
      write_reg(srfd_pkg::REG_FRAME_HEIGHT, 2);
      @(posedge clock);
      queue_byte(8'h01); queue_byte(8'h44);
      queue_byte(srfd_pkg::LINE_END);
      wait_idle();

      // random frames over a spread of sizes
      set_frame(5, 3);
      run_random(5, 3, 55, 1'b0);
      set_frame(1, 1);
      run_random(1, 1, 40, 1'b1);
      set_frame(37, 6);
      run_random(37, 6, 60, 1'b0);
      set_frame(1024, 4);
      run_random(1024, 4, 55, 1'b0);
      set_frame(16, 1024);
      run_random(16, 2, 30, 1'b1);
      set_frame(16, 3);
      run_random(16, 3, 40, 1'b0);
      set_frame(20, 5);
      run_random(20, 5, 60, 1'b0);

      wait_idle();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && expected_writes.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
